[rtl/http_chunked_stream_decoder_defines.svh]
// Assertion macros shared by the chunked stream decoder RTL.
`ifndef HTTP_CHUNKED_STREAM_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HCSD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcsd: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HCSD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcsd: assertion failed");

`endif

[rtl/hcsd_pkg.sv]
// Shared types, constants and helpers for the chunked stream decoder.
package hcsd_pkg;

    localparam int SIZE_WIDTH = 31;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        PH_SIZE    = 2'd0,
        PH_DATA    = 2'd1,
        PH_TRAILER = 2'd2,
        PH_DROP    = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ZERO    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_read;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        kind_t             kind;
    } out_item_t;

    typedef struct packed {
        phase_t phase;
        logic   count_zero;
    } core_status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Hex digit decode: 0-9, a-f, A-F
    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

[rtl/hcsd_stream_if.sv]
// Valid/ready stream interfaces for the decoder input and output channels.
interface hcsd_in_if
    import hcsd_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_read;

    modport source (output valid, output in_byte, output end_of_read, input ready);
    modport sink   (input valid, input in_byte, input end_of_read, output ready);
endinterface

interface hcsd_out_if
    import hcsd_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;

    modport source (output valid, output out_byte, output kind, input ready);
    modport sink   (input valid, input out_byte, input kind, output ready);
endinterface

[rtl/hcsd_in_stage.sv]
// Input register: captures one byte transaction ahead of the parse step.
module hcsd_in_stage
    import hcsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hcsd_in_if.sink       rx,
    input  logic          advance,
    output logic          valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // Take a new transaction when empty or when the held one moves on
    assign rx.ready = !valid_reg || advance;
    assign load     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.in_byte     <= rx.in_byte;
            item_reg.end_of_read <= rx.end_of_read;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

[rtl/hcsd_core.sv]
// Chunk framing state and the combinational per-byte parse step.
module hcsd_core
    import hcsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         advance,
    input  in_item_t     item,
    output logic         res_valid,
    output out_item_t    res,
    output core_status_t status
);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [SIZE_WIDTH-1:0] acc_reg;
    logic [SIZE_WIDTH-1:0] acc_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic                  bad_reg;
    logic                  bad_next;
    logic [SIZE_WIDTH-1:0] rem_reg;
    logic [SIZE_WIDTH-1:0] rem_next;
    logic                  step_res;
    hex_t                  hex;

    // Parse step for the held byte
    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        seen_next    = seen_reg;
        bad_next     = bad_reg;
        rem_next     = rem_reg;
        step_res     = 1'b0;
        res.out_byte = '0;
        res.kind     = KIND_PAYLOAD;
        hex          = hex_decode(item.in_byte);

        case (phase_reg)
            PH_SIZE:
            begin
                if (item.in_byte == CHAR_CR)
                begin
                    // carriage return is skipped
                end
                else if (item.in_byte != CHAR_LF)
                begin
                    if (!hex.ok)
                    begin
                        bad_next = 1'b1;
                    end
                    else if (!bad_reg)
                    begin
                        // top nibble set: another digit would overflow
                        if (acc_reg[SIZE_WIDTH-1:SIZE_WIDTH-4] != '0)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            acc_next  = {acc_reg[SIZE_WIDTH-5:0], hex.val};
                            seen_next = 1'b1;
                        end
                    end
                end
                else if (!bad_reg && seen_reg && acc_reg != '0)
                begin
                    rem_next   = acc_reg;
                    acc_next   = '0;
                    seen_next  = 1'b0;
                    bad_next   = 1'b0;
                    phase_next = PH_DATA;
                end
                else
                begin
                    step_res   = 1'b1;
                    res.kind   = (!bad_reg && seen_reg) ? KIND_ZERO : KIND_BAD;
                    acc_next   = '0;
                    seen_next  = 1'b0;
                    bad_next   = 1'b0;
                    phase_next = item.end_of_read ? PH_SIZE : PH_DROP;
                end
            end
            PH_DATA:
            begin
                step_res     = 1'b1;
                res.out_byte = item.in_byte;
                rem_next     = rem_reg - SIZE_WIDTH'(1);
                if (rem_next == '0)
                begin
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                if (item.in_byte == CHAR_LF)
                begin
                    phase_next = PH_SIZE;
                end
            end
            default:
            begin
                // drop until the end of the current read
                if (item.end_of_read)
                begin
                    phase_next = PH_SIZE;
                end
            end
        endcase
    end

    // State update once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            rem_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            bad_reg   <= bad_next;
            rem_reg   <= rem_next;
        end
    end

    assign res_valid         = item_valid && step_res;
    assign status.phase      = phase_reg;
    assign status.count_zero = (rem_reg == '0);

endmodule

[rtl/hcsd_out_stage.sv]
// Output register holding one result transaction for the sink.
module hcsd_out_stage
    import hcsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  out_item_t     res,
    output logic          can_take,
    hcsd_out_if.source    tx
);

    logic      valid_reg;
    out_item_t item_reg;

    // Free when empty or being drained this cycle
    assign can_take = !valid_reg || tx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && res_valid)
        begin
            item_reg <= res;
        end
    end

    assign tx.valid    = valid_reg;
    assign tx.out_byte = item_reg.out_byte;
    assign tx.kind     = item_reg.kind;

endmodule

[rtl/http_chunked_stream_decoder.sv]
// Path: an input byte is held in the input register and its result is registered in the output register.
// Throughput: one byte per cycle while the output side has room; the parse step (hex shift-add or count
// decrement) is combinational between the input and output registers.
// Bytes that produce no result still pass through the parse step.
// Reset: rst_n asynchronous active low; size phase, counters and flags clear,
// both pipeline registers empty.
`include "http_chunked_stream_decoder_defines.svh"

module http_chunked_stream_decoder
    import hcsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hcsd_in_if.sink    rx,
    hcsd_out_if.source tx
);

    logic         s1_valid;
    in_item_t     s1_item;
    logic         advance;
    logic         can_take;
    logic         res_valid;
    out_item_t    res;
    core_status_t status;

    // Parse step moves when a byte is held and the output side has room
    assign advance = s1_valid && can_take;

    hcsd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .valid   (s1_valid),
        .item    (s1_item)
    );

    hcsd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid),
        .advance    (advance),
        .item       (s1_item),
        .res_valid  (res_valid),
        .res        (res),
        .status     (status)
    );

    hcsd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take),
        .tx        (tx)
    );

    // Checks
    `HCSD_ASSERT_IMP(a_event_byte_zero, tx.valid && tx.kind != KIND_PAYLOAD, tx.out_byte == '0)
    `HCSD_ASSERT_IMP(a_data_count_live, status.phase == PH_DATA, !status.count_zero)
    `HCSD_ASSERT_NXT(a_data_gives_payload, advance && status.phase == PH_DATA, tx.valid && tx.kind == KIND_PAYLOAD)

endmodule

[test/http_chunked_stream_decoder_tb.sv]
// Self-checking testbench for the HTTP chunked stream decoder.
module http_chunked_stream_decoder_tb;
    import hcsd_pkg::*;

    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    // Largest accumulator value that may still take another hex digit.
    localparam logic [31:0] ACC_LIMIT = (32'h1 << (SIZE_WIDTH - 4)) - 32'h1;

    logic clk = 1'b0;
    logic rst_n;

    hcsd_in_if  rx_if ();
    hcsd_out_if tx_if ();

    http_chunked_stream_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    // Decoder state mirror
    phase_t                dec_phase;
    logic [31:0]           size_acc;
    logic                  digit_seen;
    logic                  line_bad;
    logic [SIZE_WIDTH-1:0] left_count;

    out_item_t   decoded_q[$];
    logic [7:0]  stream_q[$];
    out_item_t   want_item;
    int          mismatches = 0;
    int          live_bytes = 0;
    int          send_idle  = 0;
    int          recv_stall = 0;
    int          hold_left  = 0;
    int          cycles     = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hex digit value, or -1 for anything else
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic void clear_line();
        size_acc   = '0;
        digit_seen = 1'b0;
        line_bad   = 1'b0;
    endfunction

    // Advance the mirror by one stream byte, queueing any decoded output
    function automatic void decode_byte(input logic [7:0] b, input logic eor);
        int d;
        out_item_t r;
        case (dec_phase)
            PH_SIZE:
            begin
                if (b != CHAR_CR && b != CHAR_LF)
                begin
                    d = nibble_of(b);
                    if (d < 0)
                        line_bad = 1'b1;
                    else if (!line_bad)
                    begin
                        if (size_acc > ACC_LIMIT)
                            line_bad = 1'b1;
                        else
                        begin
                            size_acc   = (size_acc << 4) | 32'(d);
                            digit_seen = 1'b1;
                        end
                    end
                end
                else if (b == CHAR_LF)
                begin
                    if (!line_bad && digit_seen && size_acc != 0)
                    begin
                        left_count = size_acc[SIZE_WIDTH-1:0];
                        clear_line();
                        dec_phase = PH_DATA;
                    end
                    else
                    begin
                        r.out_byte = '0;
                        r.kind     = (!line_bad && digit_seen) ? KIND_ZERO : KIND_BAD;
                        decoded_q.push_back(r);
                        clear_line();
                        dec_phase = eor ? PH_SIZE : PH_DROP;
                    end
                end
            end
            PH_DATA:
            begin
                r.out_byte = b;
                r.kind     = KIND_PAYLOAD;
                decoded_q.push_back(r);
                left_count = left_count - 1'b1;
                if (left_count == 0)
                    dec_phase = PH_TRAILER;
            end
            PH_TRAILER:
            begin
                if (b == CHAR_LF)
                    dec_phase = PH_SIZE;
            end
            default:
            begin
                if (eor)
                    dec_phase = PH_SIZE;
            end
        endcase
    endfunction

    // Offer one byte, wait for acceptance, then maybe idle
    task automatic send_byte(input logic [7:0] b, input logic eor);
        rx_if.valid       <= 1'b1;
        rx_if.in_byte     <= b;
        rx_if.end_of_read <= eor;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        if (dec_phase != PH_DROP)
            live_bytes++;
        decode_byte(b, eor);
        while ($urandom_range(0, 99) < send_idle)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop offering, wait out all pending outputs and the pipeline
    task automatic drain();
        rx_if.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] foreign_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = 8'h2B;   // '+'
            1: c = 8'h2D;   // '-'
            2: c = 8'h20;   // space
            3: c = 8'h78;   // 'x'
            default:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (nibble_of(c) >= 0 || c == CHAR_CR || c == CHAR_LF);
            end
        endcase
        return c;
    endfunction

    function automatic void push_digits(input logic [31:0] value, input int zeros);
        logic [7:0] digits[$];
        logic [31:0] v;
        v = value;
        do
        begin
            digits.push_front(hex_char(v[3:0]));
            v = v >> 4;
        end
        while (v != 0);
        repeat (zeros) digits.push_front(8'h30);
        foreach (digits[i])
            stream_q.push_back(digits[i]);
    endfunction

    function automatic void push_line_end(input bit use_cr);
        if (use_cr)
            stream_q.push_back(CHAR_CR);
        stream_q.push_back(CHAR_LF);
    endfunction

    function automatic void push_chunk(input int unsigned size);
        logic [7:0] junk;
        push_digits(size, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        push_line_end($urandom_range(0, 4) != 0);
        repeat (size) stream_q.push_back(8'($urandom_range(0, 255)));
        // trailer: usually CRLF, sometimes junk before the LF
        if ($urandom_range(0, 4) != 0)
            push_line_end(1'b1);
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                do
                    junk = 8'($urandom_range(0, 255));
                while (junk == CHAR_LF);
                stream_q.push_back(junk);
            end
            stream_q.push_back(CHAR_LF);
        end
    endfunction

    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 16);
        if (r < 9)
            return $urandom_range(17, 64);
        return $urandom_range(65, 300);
    endfunction

    // Send the built read batch; end_of_read on the last byte and now and then inside
    task automatic flush_batch();
        int n;
        n = stream_q.size();
        for (int i = 0; i < n; i++)
            send_byte(stream_q[i], (i == n - 1) || ($urandom_range(0, 23) == 0));
        stream_q.delete();
    endtask

    function automatic void build_good_batch();
        repeat ($urandom_range(1, 3)) push_chunk(pick_size());
        // occasional last-chunk marker
        if ($urandom_range(0, 9) == 0)
        begin
            push_digits(0, $urandom_range(0, 2));
            push_line_end($urandom_range(0, 1));
            if ($urandom_range(0, 1))
                push_line_end(1'b1);
        end
    endfunction

    function automatic void build_broken_batch();
        int unsigned size;
        case ($urandom_range(0, 5))
            0:
            begin
                repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom_range(0, 255)));
            end
            1:
                push_line_end($urandom_range(0, 1));
            2:
            begin
                if ($urandom_range(0, 1))
                    push_digits($urandom_range(1, 255), 0);
                stream_q.push_back(foreign_char());
                if ($urandom_range(0, 1))
                    push_digits($urandom_range(0, 4095), 0);
                push_line_end($urandom_range(0, 1));
            end
            3:
            begin
                // size beyond the 31-bit range
                if ($urandom_range(0, 1))
                    push_digits({4'($urandom_range(8, 15)), 28'($urandom)}, 0);
                else
                begin
                    push_digits($urandom_range(1, 15), 0);
                    repeat ($urandom_range(8, 10)) stream_q.push_back(hex_char(4'($urandom)));
                end
                push_line_end($urandom_range(0, 1));
            end
            4:
            begin
                // chunk cut short, then garbage
                size = $urandom_range(4, 20);
                push_digits(size, 0);
                push_line_end(1'b1);
                repeat ($urandom_range(1, size - 1)) stream_q.push_back(8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                push_digits(0, $urandom_range(0, 3));
                push_line_end($urandom_range(0, 1));
            end
        endcase
        if ($urandom_range(0, 1))
            push_chunk($urandom_range(1, 8));
    endfunction

    // Edge values, each event type, drop to end of read
    task automatic test_directed();
        send_idle  = 0;
        recv_stall = 0;
        // one-byte chunk carrying 0xFF
        send_byte(8'h31, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        // zero-size chunk at end of read
        send_byte(8'h30, 1'b0);
        send_byte(CHAR_LF, 1'b1);
        // empty size line
        send_byte(CHAR_LF, 1'b1);
        // signed size, then bytes dropped up to the end of the read
        send_byte(8'h2D, 1'b0);
        send_byte(8'h31, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h35, 1'b1);
        // 0x80000000 overflows
        send_byte(8'h38, 1'b0);
        repeat (7) send_byte(8'h30, 1'b0);
        send_byte(CHAR_LF, 1'b1);
        // one-byte chunk carrying 0x00, LF-only framing
        send_byte(8'h31, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CHAR_LF, 1'b1);
        drain();
    endtask

    task automatic test_traffic(input int idle_pct, input int stall_pct, input int target);
        int start;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        start      = live_bytes;
        while (live_bytes - start < target)
        begin
            if ($urandom_range(0, 99) < 75)
                build_good_batch();
            else
                build_broken_batch();
            flush_batch();
        end
        drain();
    endtask

    // Output held off while a long chunk is streamed in
    task automatic test_backpressure();
        send_idle  = 0;
        recv_stall = 0;
        hold_left  = HOLD_CYCLES;
        push_chunk(150);
        flush_batch();
        drain();
    endtask

    // Largest legal size 0x7FFFFFFF; the chunk never ends, so this goes last
    task automatic test_max_size();
        send_idle  = 33;
        recv_stall = 33;
        stream_q.push_back(8'h37);
        repeat (7) stream_q.push_back($urandom_range(0, 1) ? 8'h66 : 8'h46);
        push_line_end(1'b1);
        repeat (300) stream_q.push_back(8'($urandom_range(0, 255)));
        flush_batch();
        drain();
    endtask

    // Output ready, with long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            tx_if.ready <= 1'b0;
        end
        else
            tx_if.ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // Compare each output transaction with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: expected no output, got byte=%h kind=%0d", $time,
                         tx_if.out_byte, tx_if.kind);
                mismatches++;
            end
            else
            begin
                want_item = decoded_q.pop_front();
                if (tx_if.out_byte !== want_item.out_byte)
                begin
                    $display("%0t: out_byte expected %h got %h", $time,
                             want_item.out_byte, tx_if.out_byte);
                    mismatches++;
                end
                if (tx_if.kind !== want_item.kind)
                begin
                    $display("%0t: kind expected %0d got %0d", $time,
                             want_item.kind, tx_if.kind);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        rx_if.valid       = 1'b0;
        rx_if.in_byte     = '0;
        rx_if.end_of_read = 1'b0;
        tx_if.ready       = 1'b0;
        dec_phase         = PH_SIZE;
        clear_line();
        left_count        = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_traffic(0, 0, 280);
        test_traffic(69, 0, 280);
        test_traffic(0, 69, 280);
        test_traffic(33, 33, 280);
        test_backpressure();
        test_max_size();

        if (mismatches == 0 && decoded_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
